FILE: rtl/core/sixteen_bit_stack_cpu_core_unit_assert.svh
// Assertion macros for the stack CPU core checker.
`ifndef SIXTEEN_BIT_STACK_CPU_CORE_UNIT_ASSERT_SVH
`define SIXTEEN_BIT_STACK_CPU_CORE_UNIT_ASSERT_SVH
`define SBC_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
`define SBC_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

FILE: rtl/core/sbc_pkg.sv
// Package: constants and opcode codes for the stack CPU core.
`default_nettype none
package sbc_pkg;
  localparam int MEM_BYTES_DEF = 65536;
  localparam int NUM_REGS_DEF  = 16;
  localparam int STACK_REG_DEF = 15;
  localparam logic [3:0] NIBBLE_MASK = 4'hf;

  localparam logic [7:0] OP_RET = 8'h01, OP_CLD = 8'h02, OP_STD = 8'h03, OP_NEG = 8'h04;
  localparam logic [7:0] OP_NOT = 8'h05, OP_PUSH = 8'h06, OP_POP = 8'h07, OP_JMPR = 8'h08;
  localparam logic [7:0] OP_CALLR = 8'h09, OP_OUT = 8'h0a, OP_INC = 8'h0b, OP_DEC = 8'h0c;
  localparam logic [7:0] OP_BR = 8'h0d, OP_JR = 8'h0e, OP_ADD = 8'h0f, OP_SUB = 8'h10;
  localparam logic [7:0] OP_MUL = 8'h11, OP_DIV = 8'h12, OP_AND = 8'h13, OP_OR = 8'h14;
  localparam logic [7:0] OP_XOR = 8'h15, OP_SHL = 8'h16, OP_SHR = 8'h17, OP_TEST = 8'h18;
  localparam logic [7:0] OP_CMP = 8'h19, OP_EQU = 8'h1a, OP_MOV = 8'h1b, OP_LOAD = 8'h1c;
  localparam logic [7:0] OP_STOR = 8'h1d, OP_LOADB = 8'h1e, OP_STORB = 8'h1f;
  localparam logic [7:0] OP_JMP = 8'h20, OP_CALL = 8'h21, OP_LOADI = 8'h22;

  localparam logic [2:0] ALU_ADD = 3'd0, ALU_SUB = 3'd1, ALU_AND = 3'd2, ALU_OR = 3'd3;
  localparam logic [2:0] ALU_XOR = 3'd4, ALU_SHL = 3'd5, ALU_SHR = 3'd6, ALU_PASS = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] x;
    logic [15:0] y;
  } alu_req_t;
endpackage
`default_nettype wire

FILE: rtl/core/sbc_if.sv
// Valid/ready channel interface.
`default_nettype none
interface sbc_if #(parameter int W = 8) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sbc_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module sbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/sbc_alu.sv
// Shared 16-bit add/subtract/logic/shift unit.
`default_nettype none
module sbc_alu (
  input  wire sbc_pkg::alu_req_t req,
  output logic [15:0]            res
);
  always_comb begin
    case (req.op)
      sbc_pkg::ALU_ADD: res = req.x + req.y;
      sbc_pkg::ALU_SUB: res = req.x - req.y;
      sbc_pkg::ALU_AND: res = req.x & req.y;
      sbc_pkg::ALU_OR:  res = req.x | req.y;
      sbc_pkg::ALU_XOR: res = req.x ^ req.y;
      sbc_pkg::ALU_SHL: res = (req.y[15:4] != 12'd0) ? 16'd0 : (req.x << req.y[3:0]);
      sbc_pkg::ALU_SHR: res = (req.y[15:4] != 12'd0) ? 16'd0 : (req.x >> req.y[3:0]);
      default:          res = req.x;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/core/sixteen_bit_stack_cpu_core_unit.sv
// Top level of the sixteen-bit stack CPU core.
//  channel | dir | payload
//  in_ch   | in  | opcode, load_address, load_byte
//  out_ch  | out | fault, char_valid, char_out, program_counter, condition, debug_mode
// A write request stores its byte and then loads its result; an execute request's run time
// is set by byte-wide memory fetch (one RAM port, one byte per access, up to four
// instruction bytes and two operand bytes) and by the 16-step shift/add multiply in the
// shared ALU and the 16-step shift/subtract divide.
// rst clears registers, flags and pc; memory is not cleared.
// A result waits in the output register; the next request may run meanwhile, and its
// result is loaded in the cycle after the register has been emptied.
`default_nettype none
module sixteen_bit_stack_cpu_core_unit #(
  parameter int MEM_BYTES = sbc_pkg::MEM_BYTES_DEF,
  parameter int STACK_REG = sbc_pkg::STACK_REG_DEF
) (
  input wire logic clk,
  input wire logic rst,
  sbc_if.sink      in_ch,
  sbc_if.source    out_ch
);
  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [3:0] SPI = 4'(STACK_REG);
  localparam logic [15:0] PC_MASK = 16'(MEM_BYTES - 1);

  localparam logic [4:0] S_IDLE = 5'd0, S_RD = 5'd1, S_RDW = 5'd2, S_DEC = 5'd3,
    S_EXEC = 5'd4, S_ITER = 5'd5, S_WR = 5'd6, S_OUT = 5'd7, S_WLD = 5'd8;

  logic [4:0]  state;
  logic [15:0] regs [sbc_pkg::NUM_REGS_DEF];
  logic [15:0] pc;
  logic        cond, dbg, halted;
  logic [7:0]  op, rb;
  logic [15:0] imm, va, vb, acc, quo, tmp;
  logic [4:0]  cnt;
  logic [2:0]  bidx;       // bytes to fetch in sequence
  logic [2:0]  phase;
  logic [15:0] raddr;
  logic        emit;
  logic [7:0]  ch;
  logic        mwe;
  logic [15:0] maddr;
  logic [7:0]  mwd, mrd;
  logic [15:0] wq;
  logic [15:0] waddr;
  logic [1:0]  wleft;
  logic [15:0] alu_res;
  sbc_pkg::alu_req_t alu_req;

  sbc_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
    .clk(clk), .we(mwe), .addr(maddr[AW-1:0]), .wdata(mwd), .rdata(mrd));
  sbc_alu u_alu (.req(alu_req), .res(alu_res));

  wire [3:0] r1 = rb[7:4];
  wire [3:0] r2 = rb[3:0] & sbc_pkg::NIBBLE_MASK;
  wire [16:0] dsub = {acc, quo[15]} - {1'b0, va};

  assign in_ch.ready = (state == S_IDLE);

  always_comb begin
    alu_req = '{op: sbc_pkg::ALU_PASS, x: va, y: vb};
    if (state == S_ITER) begin
      alu_req = '{op: sbc_pkg::ALU_ADD, x: acc, y: (quo[0] ? vb : 16'd0)};
    end else begin
      case (op)
        sbc_pkg::OP_ADD:  alu_req = '{op: sbc_pkg::ALU_ADD, x: vb, y: va};
        sbc_pkg::OP_SUB:  alu_req = '{op: sbc_pkg::ALU_SUB, x: vb, y: va};
        sbc_pkg::OP_NEG:  alu_req = '{op: sbc_pkg::ALU_SUB, x: 16'd0, y: va};
        sbc_pkg::OP_INC:  alu_req = '{op: sbc_pkg::ALU_ADD, x: va, y: 16'd1};
        sbc_pkg::OP_DEC:  alu_req = '{op: sbc_pkg::ALU_SUB, x: va, y: 16'd1};
        sbc_pkg::OP_AND, sbc_pkg::OP_TEST:
                          alu_req = '{op: sbc_pkg::ALU_AND, x: vb, y: va};
        sbc_pkg::OP_OR:   alu_req = '{op: sbc_pkg::ALU_OR, x: vb, y: va};
        sbc_pkg::OP_XOR:  alu_req = '{op: sbc_pkg::ALU_XOR, x: vb, y: va};
        sbc_pkg::OP_SHL:  alu_req = '{op: sbc_pkg::ALU_SHL, x: vb, y: va};
        sbc_pkg::OP_SHR:  alu_req = '{op: sbc_pkg::ALU_SHR, x: vb, y: va};
        sbc_pkg::OP_BR, sbc_pkg::OP_JR:
          alu_req = '{op: sbc_pkg::ALU_ADD, x: pc, y: {{8{rb[7]}}, rb} - 16'd2};
        default: alu_req = '{op: sbc_pkg::ALU_PASS, x: va, y: vb};
      endcase
    end
  end

  always_comb begin
    mwe = 1'b0; maddr = raddr; mwd = 8'd0;
    if (state == S_WLD) begin
      mwe = 1'b1; maddr = waddr; mwd = tmp[7:0];
    end else if (state == S_WR) begin
      mwe = 1'b1; maddr = waddr;
      mwd = (wleft == 2'd2) ? wq[15:8] : wq[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; pc <= 16'd0; cond <= 1'b0; dbg <= 1'b0; halted <= 1'b0;
      out_ch.valid <= 1'b0;
      for (int i = 0; i < sbc_pkg::NUM_REGS_DEF; i++) regs[i] <= 16'd0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          emit <= 1'b0; ch <= 8'd0;
          if (!in_ch.data[24]) begin
            waddr <= in_ch.data[23:8]; tmp <= {8'd0, in_ch.data[7:0]};
            state <= S_WLD;
          end else if (halted) state <= S_OUT;
          else begin
            raddr <= pc; phase <= 3'd0; bidx <= 3'd2; state <= S_RD;
          end
        end
        S_WLD: state <= S_OUT;
        S_RD: state <= S_RDW;
        S_RDW: begin
          // phase 0,1: op, rb; 2,3: imm; 4,5: load data
          case (phase)
            3'd0: op <= mrd;
            3'd1: rb <= mrd;
            3'd2: imm[15:8] <= mrd;
            3'd3: imm[7:0] <= mrd;
            3'd4: tmp[15:8] <= mrd;
            default: tmp[7:0] <= mrd;
          endcase
          raddr <= raddr + 16'd1;
          phase <= phase + 3'd1;
          if (bidx == 3'd1) begin
            state <= S_DEC;
            if (phase == 3'd1) pc <= (pc + 16'd2) & PC_MASK;
            if (phase == 3'd3) pc <= (pc + 16'd2) & PC_MASK;
          end else state <= S_RD;
          bidx <= bidx - 3'd1;
        end
        S_DEC: begin
          if (phase == 3'd2 && (op inside {[sbc_pkg::OP_JMP:sbc_pkg::OP_LOADI]})) begin
            raddr <= pc; bidx <= 3'd2; state <= S_RD;
          end else begin
            va <= regs[r1]; vb <= regs[r2];
            phase <= 3'd4;
            state <= S_EXEC;
            if (phase == 3'd4) state <= S_EXEC;
            if (phase < 3'd4) begin
              // pre-load memory operands
              case (op)
                sbc_pkg::OP_RET, sbc_pkg::OP_POP: begin
                  raddr <= regs[SPI]; bidx <= 3'd2; state <= S_RD;
                end
                sbc_pkg::OP_LOAD: begin
                  raddr <= regs[r1]; bidx <= 3'd2; state <= S_RD;
                end
                sbc_pkg::OP_LOADB: begin
                  raddr <= regs[r1]; tmp[15:8] <= 8'd0; phase <= 3'd5;
                  bidx <= 3'd1; state <= S_RD;
                end
                default: ;
              endcase
            end
          end
        end
        S_EXEC: begin
          state <= S_OUT;
          case (op)
            sbc_pkg::OP_RET: begin pc <= tmp; regs[SPI] <= regs[SPI] + 16'd2; end
            sbc_pkg::OP_CLD: dbg <= 1'b0;
            sbc_pkg::OP_STD: dbg <= 1'b1;
            sbc_pkg::OP_NEG, sbc_pkg::OP_INC, sbc_pkg::OP_DEC: regs[r1] <= alu_res;
            sbc_pkg::OP_NOT: regs[r1] <= {15'd0, va == 16'd0};
            sbc_pkg::OP_PUSH, sbc_pkg::OP_CALLR, sbc_pkg::OP_CALL: begin
              regs[SPI] <= regs[SPI] - 16'd2; waddr <= regs[SPI] - 16'd2;
              wq <= (op == sbc_pkg::OP_PUSH) ? regs[r1] : pc;
              wleft <= 2'd2; state <= S_WR;
              if (op == sbc_pkg::OP_CALLR) pc <= va;
              if (op == sbc_pkg::OP_CALL) pc <= imm;
            end
            sbc_pkg::OP_POP: begin
              regs[SPI] <= regs[SPI] + 16'd2; regs[r1] <= tmp;
            end
            sbc_pkg::OP_JMPR: pc <= va;
            sbc_pkg::OP_OUT: begin emit <= 1'b1; ch <= va[7:0]; end
            sbc_pkg::OP_BR: if (cond) pc <= alu_res;
            sbc_pkg::OP_JR: pc <= alu_res;
            sbc_pkg::OP_ADD, sbc_pkg::OP_SUB, sbc_pkg::OP_AND, sbc_pkg::OP_OR,
            sbc_pkg::OP_XOR, sbc_pkg::OP_SHL, sbc_pkg::OP_SHR: regs[r2] <= alu_res;
            sbc_pkg::OP_MUL: begin
              acc <= 16'd0; quo <= va; cnt <= 5'd16; state <= S_ITER;
            end
            sbc_pkg::OP_DIV: begin
              if (va == 16'd0) regs[r2] <= 16'hffff;
              else begin acc <= 16'd0; quo <= vb; cnt <= 5'd16; state <= S_ITER; end
            end
            sbc_pkg::OP_TEST: cond <= alu_res != 16'd0;
            sbc_pkg::OP_CMP: cond <= va < vb;
            sbc_pkg::OP_EQU: cond <= va == vb;
            sbc_pkg::OP_MOV: regs[r2] <= va;
            sbc_pkg::OP_LOAD, sbc_pkg::OP_LOADB: regs[r2] <= tmp;
            sbc_pkg::OP_STOR: begin
              waddr <= vb; wq <= va; wleft <= 2'd2; state <= S_WR;
            end
            sbc_pkg::OP_STORB: begin
              waddr <= vb; wq <= va; wleft <= 2'd1; state <= S_WR;
            end
            sbc_pkg::OP_JMP: pc <= imm;
            sbc_pkg::OP_LOADI: regs[r1] <= imm;
            default: halted <= 1'b1;
          endcase
        end
        S_ITER: begin
          cnt <= cnt - 5'd1;
          if (op == sbc_pkg::OP_MUL) begin
            acc <= alu_res; vb <= vb << 1; quo <= quo >> 1;
          end else begin
            if (!dsub[16]) begin
              acc <= dsub[15:0]; quo <= {quo[14:0], 1'b1};
            end else begin
              acc <= {acc[14:0], quo[15]}; quo <= {quo[14:0], 1'b0};
            end
          end
          if (cnt == 5'd1) state <= S_WR;
          wleft <= 2'd0;
        end
        S_WR: begin
          if (wleft == 2'd0) begin
            regs[r2] <= (op == sbc_pkg::OP_MUL) ? acc : quo;
            state <= S_OUT;
          end else begin
            waddr <= waddr + 16'd1;
            wleft <= wleft - 2'd1;
            if (wleft == 2'd1) state <= S_OUT;
          end
        end
        S_OUT: if (!out_ch.valid) begin
          out_ch.valid <= 1'b1;
          out_ch.data <= {halted, emit, ch, pc, cond, dbg};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/sbc_checker.sv
// Port-level checker for the stack CPU core, bound to the top level.
`default_nettype none
`include "sixteen_bit_stack_cpu_core_unit_assert.svh"
module sbc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [27:0] out_data
);
  `SBC_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
  `SBC_ASSERT_IMPL(a_char_zero, out_valid && !out_data[26], out_data[25:18] == 8'd0)
  `SBC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `SBC_ASSERT_IMPL(a_known, out_valid, !$isunknown({in_ready, out_data}))
endmodule

bind sixteen_bit_stack_cpu_core_unit sbc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
`default_nettype wire
